// File: rtl/core/ssa_pkg.sv
package ssa_pkg;

  localparam int SCORE_W     = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // one classified input transaction on its way to the back end
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               last;
    logic               keep;
  } ssa_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ssa_qstat_t;

endpackage

// File: rtl/core/ssa_ram.sv
module ssa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ssa_queue.sv
module ssa_queue
  import ssa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  ssa_entry_t push_entry,
  input  logic       pop,
  output ssa_entry_t head_entry,
  output ssa_qstat_t stat
);

  ssa_entry_t        slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QPTR_W:0]   count_r;

  assign stat.full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_entry = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + (QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (QPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/core/ssa_front.sv
module ssa_front
  import ssa_pkg::*;
#(
  parameter int MAX_SCORES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SCORE_W-1:0] in_score,
  input  logic               in_last,
  input  logic               q_full,
  output logic               push,
  output ssa_entry_t         push_entry
);

  localparam int CNT_W = $clog2(MAX_SCORES + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             keep;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  // mark scores past the store depth for dropping
  assign keep     = (cnt_r < CNT_W'(MAX_SCORES));

  assign push_entry.score = in_score;
  assign push_entry.last  = in_last;
  assign push_entry.keep  = keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (push) begin
      if (in_last) begin
        cnt_r <= '0;
      end else if (keep) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/ssa_div.sv
module ssa_div #(
  parameter int DIVIDEND_W = 30,
  parameter int DIVISOR_W  = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic                  neg_r;
  logic [DIVIDEND_W-1:0] quot_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic [STEP_W-1:0]     step_r;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // restoring division on the magnitude, one quotient bit per cycle
  assign shifted = {rem_r, quot_r[DIVIDEND_W-1]};
  assign fits    = (shifted >= {1'b0, dvs_r});
  assign diff    = shifted - {1'b0, dvs_r};

  assign done     = done_r;
  // truncate toward zero: apply the sign to the magnitude quotient
  assign quotient = neg_r ? (~quot_r + DIVIDEND_W'(1)) : quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        neg_r  <= dividend[DIVIDEND_W-1];
        quot_r <= dividend[DIVIDEND_W-1] ? (~dividend + DIVIDEND_W'(1)) : dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r  <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        quot_r <= {quot_r[DIVIDEND_W-2:0], fits};
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/ssa_back.sv
module ssa_back
  import ssa_pkg::*;
#(
  parameter int MAX_SCORES = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ssa_entry_t                            q_entry,
  input  logic                                  q_empty,
  output logic                                  pop,
  output logic                                  div_start,
  output logic [SCORE_W+$clog2(MAX_SCORES)-1:0] div_dividend,
  output logic [$clog2(MAX_SCORES+1)-1:0]       div_divisor,
  input  logic                                  div_done,
  input  logic [SCORE_W+$clog2(MAX_SCORES)-1:0] div_quot,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [SCORE_W-1:0]                    out_sorted_score,
  output logic [SCORE_W-1:0]                    out_average,
  output logic                                  out_overflow,
  output logic                                  out_last_out
);

  localparam int CNT_W = $clog2(MAX_SCORES + 1);
  localparam int AW    = $clog2(MAX_SCORES);
  localparam int SUM_W = SCORE_W + $clog2(MAX_SCORES);

  typedef enum logic [3:0] {
    S_LOAD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_HEAD,
    S_SCAN,
    S_SWAP_A,
    S_SWAP_B,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SUM_W-1:0]   sum_r;
  logic               drop_r;
  logic [CNT_W-1:0]   head_r;
  logic [CNT_W-1:0]   probe_r;
  logic [CNT_W-1:0]   pick_r;
  logic [CNT_W-1:0]   rd_idx_r;
  logic               rd_vld_r;
  logic [SCORE_W-1:0] least_r;
  logic [SCORE_W-1:0] held_r;
  logic [CNT_W-1:0]   k_r;
  logic [SCORE_W-1:0] mean_r;
  logic [SCORE_W-1:0] score_out_r;
  logic               last_out_r;
  logic               out_valid_r;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [SCORE_W-1:0] wdata;
  logic [AW-1:0]      raddr;
  logic [SCORE_W-1:0] rdata;
  logic               probe_left;

  ssa_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (MAX_SCORES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign pop          = (state_r == S_LOAD) && !q_empty;
  assign div_start    = (state_r == S_DIV_GO);
  assign div_dividend = sum_r;
  assign div_divisor  = cnt_r;
  assign probe_left   = (probe_r < cnt_r);

  assign out_valid        = out_valid_r;
  assign out_sorted_score = score_out_r;
  assign out_average      = mean_r;
  assign out_overflow     = drop_r;
  assign out_last_out     = last_out_r;

  always_comb begin
    we    = 1'b0;
    waddr = cnt_r[AW-1:0];
    wdata = q_entry.score;
    priority if (pop && q_entry.keep) begin
      we = 1'b1;
    end else if (state_r == S_SWAP_A) begin
      we    = 1'b1;
      waddr = head_r[AW-1:0];
      wdata = least_r;
    end else if (state_r == S_SWAP_B) begin
      we    = 1'b1;
      waddr = pick_r[AW-1:0];
      wdata = held_r;
    end
  end

  assign raddr = (state_r == S_EMIT_RD) ? k_r[AW-1:0] : probe_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      sum_r       <= '0;
      drop_r      <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      probe_r     <= '0;
      k_r         <= '0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (pop) begin
            if (q_entry.keep) begin
              cnt_r <= cnt_r + CNT_W'(1);
              sum_r <= sum_r + {{(SUM_W-SCORE_W){q_entry.score[SCORE_W-1]}}, q_entry.score};
            end else begin
              drop_r <= 1'b1;
            end
            if (q_entry.last) begin
              state_r <= S_DIV_GO;
            end
          end
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            mean_r  <= div_quot[SCORE_W-1:0];
            head_r  <= '0;
            state_r <= S_HEAD;
          end
        end
        S_HEAD: begin
          if ((head_r + CNT_W'(1)) >= cnt_r) begin
            k_r     <= '0;
            state_r <= S_EMIT_RD;
          end else begin
            probe_r  <= head_r;
            rd_vld_r <= 1'b0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one read per cycle, fold in the data of the previous read
          if (probe_left) begin
            rd_vld_r <= 1'b1;
            rd_idx_r <= probe_r;
            probe_r  <= probe_r + CNT_W'(1);
          end else begin
            rd_vld_r <= 1'b0;
          end
          if (rd_vld_r) begin
            if (rd_idx_r == head_r) begin
              least_r <= rdata;
              held_r  <= rdata;
              pick_r  <= head_r;
            end else if ($signed(rdata) < $signed(least_r)) begin
              least_r <= rdata;
              pick_r  <= rd_idx_r;
            end
          end
          if (!probe_left && !rd_vld_r) begin
            state_r <= S_SWAP_A;
          end
        end
        S_SWAP_A: begin
          state_r <= S_SWAP_B;
        end
        S_SWAP_B: begin
          head_r  <= head_r + CNT_W'(1);
          state_r <= S_HEAD;
        end
        S_EMIT_RD: begin
          state_r <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          score_out_r <= rdata;
          last_out_r  <= ((k_r + CNT_W'(1)) == cnt_r);
          out_valid_r <= 1'b1;
          state_r     <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (last_out_r) begin
              cnt_r   <= '0;
              sum_r   <= '0;
              drop_r  <= 1'b0;
              state_r <= S_LOAD;
            end else begin
              k_r     <= k_r + CNT_W'(1);
              state_r <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/selection_sort_with_average_unit.sv
// Flow: the last score of a list reaches the store from the queue once the back end pops it; the mean
//   then comes from the divider (one quotient bit per cycle), then the sort runs (one store read per
//   compare), and each result is read, loaded and held until out_ready takes it.
// A new list is taken into the queue while one is still being sorted, but it reaches the store only
//   after the last result of the list before; the compare scan uses the single read port of the store.
// Reset: synchronous, active low; clears counts, sum, flag, queue and handshakes. The store
//   holds no reset and needs no clearing pass.
module selection_sort_with_average_unit
  import ssa_pkg::*;
#(
  parameter int MAX_SCORES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SCORE_W-1:0] in_score,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SCORE_W-1:0] out_sorted_score,
  output logic [SCORE_W-1:0] out_average,
  output logic               out_overflow,
  output logic               out_last_out
);

  localparam int CNT_W = $clog2(MAX_SCORES + 1);
  localparam int SUM_W = SCORE_W + $clog2(MAX_SCORES);

  logic             push;
  ssa_entry_t       push_entry;
  ssa_entry_t       head_entry;
  ssa_qstat_t       qstat;
  logic             pop;
  logic             div_start;
  logic [SUM_W-1:0] div_dividend;
  logic [CNT_W-1:0] div_divisor;
  logic             div_done;
  logic [SUM_W-1:0] div_quot;

  ssa_front #(
    .MAX_SCORES (MAX_SCORES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_score   (in_score),
    .in_last    (in_last),
    .q_full     (qstat.full),
    .push       (push),
    .push_entry (push_entry)
  );

  ssa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .stat       (qstat)
  );

  ssa_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  ssa_back #(
    .MAX_SCORES (MAX_SCORES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_entry          (head_entry),
    .q_empty          (qstat.empty),
    .pop              (pop),
    .div_start        (div_start),
    .div_dividend     (div_dividend),
    .div_divisor      (div_divisor),
    .div_done         (div_done),
    .div_quot         (div_quot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_score (out_sorted_score),
    .out_average      (out_average),
    .out_overflow     (out_overflow),
    .out_last_out     (out_last_out)
  );

  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty at once");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("back end popped an empty queue");

  a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_out) |=> !out_valid)
    else $error("result offered after the final sorted score");

  a_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !div_done)
    else $error("divider finished during emission");

endmodule

// File: tb/sv/selection_sort_checker.sv
`timescale 1ns / 1ps
module selection_sort_checker
  import ssa_pkg::*;
#(
  parameter int MAX_SCORES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [SCORE_W-1:0] in_score,
  input  logic               in_last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [SCORE_W-1:0] out_sorted_score,
  input  logic [SCORE_W-1:0] out_average,
  input  logic               out_overflow,
  input  logic               out_last_out,
  output int                 error_count,
  output int                 pending_count
);

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic [SCORE_W-1:0] average;
    logic               overflow;
    logic               last_out;
  } ranked_score_t;

  int            list_scores[$];
  longint        list_sum;
  logic          list_dropped;
  ranked_score_t ranked_q[$];
  int            mismatches;

  // Order the collected list, attach the mean and queue one entry per stored score.
  function automatic void rank_list();
    int            n;
    int            pick;
    int            held;
    longint        mean;
    ranked_score_t r;
    n = list_scores.size();
    if (n != 0) begin
      for (int head = 0; head + 1 < n; head++) begin
        pick = head;
        for (int probe = head + 1; probe < n; probe++) begin
          if (list_scores[probe] < list_scores[pick]) pick = probe;
        end
        held              = list_scores[head];
        list_scores[head] = list_scores[pick];
        list_scores[pick] = held;
      end
      // longint division truncates toward zero
      mean = list_sum / n;
      for (int k = 0; k < n; k++) begin
        r.score    = SCORE_W'(list_scores[k]);
        r.average  = SCORE_W'(mean);
        r.overflow = list_dropped;
        r.last_out = (k == n - 1);
        ranked_q.push_back(r);
      end
    end
    list_scores.delete();
    list_sum     = 0;
    list_dropped = 1'b0;
  endfunction

  function automatic void take_score(input logic [SCORE_W-1:0] raw, input logic fin);
    if (list_scores.size() < MAX_SCORES) begin
      list_scores.push_back(int'($signed(raw)));
      list_sum += longint'($signed(raw));
    end else begin
      list_dropped = 1'b1;
    end
    if (fin) rank_list();
  endfunction

  function automatic void check_result();
    ranked_score_t r;
    if (ranked_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result: score %0d avg %0d ovf %0b last %0b", $realtime,
                 $signed(out_sorted_score), $signed(out_average), out_overflow, out_last_out);
    end else begin
      r = ranked_q.pop_front();
      if (out_sorted_score !== r.score || out_average !== r.average ||
          out_overflow !== r.overflow || out_last_out !== r.last_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected score %0d avg %0d ovf %0b last %0b, got score %0d avg %0d ovf %0b last %0b",
                   $realtime, $signed(r.score), $signed(r.average), r.overflow, r.last_out,
                   $signed(out_sorted_score), $signed(out_average), out_overflow, out_last_out);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      list_scores.delete();
      ranked_q.delete();
      list_sum     = 0;
      list_dropped = 1'b0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) take_score(in_score, in_last);
    end
    error_count   <= mismatches;
    pending_count <= ranked_q.size();
  end

  initial begin
    mismatches    = 0;
    list_sum      = 0;
    list_dropped  = 1'b0;
    error_count   = 0;
    pending_count = 0;
  end

endmodule

// File: tb/sv/tb_selection_sort_with_average_unit.sv
`timescale 1ns / 1ps
module tb_selection_sort_with_average_unit;
  import ssa_pkg::*;

  localparam int MAX_SCORES = 64;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 24'h7FFFFF;
  localparam logic [SCORE_W-1:0] SCORE_MIN = 24'h800000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [SCORE_W-1:0] in_score;
  logic               in_last;
  logic               out_valid;
  logic               out_ready;
  logic [SCORE_W-1:0] out_sorted_score;
  logic [SCORE_W-1:0] out_average;
  logic               out_overflow;
  logic               out_last_out;

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;
  int pending_count;

  always #10 clk = ~clk;

  selection_sort_with_average_unit #(
    .MAX_SCORES(MAX_SCORES)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_score        (in_score),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sorted_score(out_sorted_score),
    .out_average     (out_average),
    .out_overflow    (out_overflow),
    .out_last_out    (out_last_out)
  );

  selection_sort_checker #(
    .MAX_SCORES(MAX_SCORES)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_score        (in_score),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sorted_score(out_sorted_score),
    .out_average     (out_average),
    .out_overflow    (out_overflow),
    .out_last_out    (out_last_out),
    .error_count     (error_count),
    .pending_count   (pending_count)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hold valid and payload until the transaction completes; drop valid only for an idle gap.
  task automatic send_score(input logic [SCORE_W-1:0] score, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_score <= score;
    in_last  <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [SCORE_W-1:0] pick_score();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return SCORE_W'($urandom);
    if (sel < 80) return SCORE_W'($signed($urandom_range(16)) - 8);
    if (sel < 90) return SCORE_MAX - SCORE_W'($urandom_range(7));
    return SCORE_MIN + SCORE_W'($urandom_range(7));
  endfunction

  task automatic send_list(input int len);
    for (int i = 0; i < len; i++) send_score(pick_score(), i == len - 1);
  endtask

  initial begin
    int phase_items;
    int len;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_score       <= '0;
    in_last        <= 1'b0;
    out_ready      <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // single-entry lists at both extremes
    send_score(SCORE_MAX, 1'b1);
    send_score(SCORE_MIN, 1'b1);
    // mixed extremes, mean -0.5 truncates to zero
    send_score(SCORE_MAX, 1'b0);
    send_score(SCORE_MIN, 1'b0);
    send_score('0, 1'b0);
    send_score('1, 1'b1);
    // negative mean truncates toward zero, not down
    send_score('1, 1'b0);
    send_score(-24'sd2, 1'b1);
    // duplicates
    send_score(24'd3, 1'b0);
    send_score(24'd3, 1'b0);
    send_score(-24'sd5, 1'b0);
    send_score(24'd3, 1'b0);
    send_score('0, 1'b1);
    // sum at the extremes
    for (int i = 0; i < 3; i++) send_score(SCORE_MAX, i == 2);
    for (int i = 0; i < 3; i++) send_score(SCORE_MIN, i == 2);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      // store filled exactly, then filled past depth so that the extra scores, the last among them, are dropped
      if (phase == 1) send_list(MAX_SCORES);
      if (phase == 3) send_list($urandom_range(MAX_SCORES + 8, MAX_SCORES + 1));
      phase_items = 0;
      while (phase_items < 45) begin
        len = $urandom_range(12, 1);
        send_list(len);
        phase_items += len;
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending_count == 0);
    repeat (50) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
